// ===== sv/mxrt_pkg.sv =====
// Shared types and constants for the mesh XY route timing reservation block.
// No dependencies; the top level of the block imports this package.
package mxrt_pkg;

    localparam int TIME_W          = 64;
    localparam int LAT_W           = 32;
    localparam int ID_W            = 4;
    localparam int COORD_W         = 4;
    localparam int NUM_IDS         = 16;
    localparam int PORTS           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int MESH_X_DEFAULT  = 4;
    localparam int MESH_Y_DEFAULT  = 4;

    typedef enum logic [2:0] {
        DIR_LOCAL = 3'd0,
        DIR_NORTH = 3'd1,
        DIR_EAST  = 3'd2,
        DIR_SOUTH = 3'd3,
        DIR_WEST  = 3'd4
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROUTER_LAT = 3'd0,
        REG_NORTH_LAT  = 3'd1,
        REG_EAST_LAT   = 3'd2,
        REG_SOUTH_LAT  = 3'd3,
        REG_WEST_LAT   = 3'd4,
        REG_BUSY_LAT   = 3'd5,
        REG_CYCLE_TIME = 3'd6,
        REG_ASYNC_MODE = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_LOAD,
        S_WAIT,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] send_time;
        logic [ID_W-1:0]   src_router;
        logic [ID_W-1:0]   dst_router;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] congestion_total;
        logic [TIME_W-1:0] traversal_total;
        logic [TIME_W-1:0] busy_total;
        logic [2:0]        hop_count;
        logic [1:0]        north_hops;
        logic [1:0]        east_hops;
        logic [1:0]        south_hops;
        logic [1:0]        west_hops;
        logic              bad_id;
    } out_item_t;

endpackage

// ===== sv/mxrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-port reservation tables.
module mxrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mesh_xy_route_timing_reserve_unit.sv =====
// Top level of the mesh XY route timing reservation block.
// Depends on mxrt_pkg and on mxrt_ram for the output and link reservation tables.
//
// Each item carries a send time and a source and destination router of the mesh. The block
// walks the XY route one hop at a time through a shared read, compare and add sequence:
// every hop, and the final local port, goes through table read, port compare, wait compare
// and commit in turn; an item with a router id out of range skips the route and goes
// straight to the result. The block accepts no item while one is in progress. After reset
// a clearing pass zeroes the reservation tables before the first item is taken;
// configuration writes are taken at any time.
module mesh_xy_route_timing_reserve_unit
    import mxrt_pkg::*;
#(
    parameter int MESH_X = MESH_X_DEFAULT,
    parameter int MESH_Y = MESH_Y_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_ROUTERS  = MESH_X * MESH_Y;
    localparam int ID_CAP       = (NUM_ROUTERS < NUM_IDS) ? NUM_ROUTERS : NUM_IDS;
    localparam int ROW_LAST     = (ID_CAP - 1) / MESH_X;
    localparam int ROUTERS_USED = (ROW_LAST + 1) * MESH_X;
    localparam int SLOTS        = ROUTERS_USED * PORTS;
    localparam int SLOT_W       = $clog2(SLOTS);

    localparam logic [SLOT_W-1:0] STEP_X    = SLOT_W'(PORTS);
    localparam logic [SLOT_W-1:0] STEP_Y    = SLOT_W'(PORTS * MESH_X);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [ID_W:0]     ID_LIMIT  = (ID_W + 1)'(ID_CAP);

    logic [COORD_W-1:0] x_tab    [NUM_IDS];
    logic [COORD_W-1:0] y_tab    [NUM_IDS];
    logic [SLOT_W-1:0]  base_tab [NUM_IDS];

    for (genvar i = 0; i < NUM_IDS; i++)
    begin : g_tab
        assign x_tab[i]    = COORD_W'(i % MESH_X);
        assign y_tab[i]    = COORD_W'(i / MESH_X);
        assign base_tab[i] = SLOT_W'(i * PORTS);
    end

    logic [LAT_W-1:0] router_lat_reg;
    logic [LAT_W-1:0] north_lat_reg;
    logic [LAT_W-1:0] east_lat_reg;
    logic [LAT_W-1:0] south_lat_reg;
    logic [LAT_W-1:0] west_lat_reg;
    logic [LAT_W-1:0] busy_lat_reg;
    logic [LAT_W-1:0] cycle_time_reg;
    logic             async_mode_reg;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic [TIME_W-1:0]  t_reg, t_next;
    logic [TIME_W-1:0]  cong_reg, cong_next;
    logic [TIME_W-1:0]  trav_reg, trav_next;
    logic [TIME_W-1:0]  busy_sum_reg, busy_sum_next;
    logic [2:0]         hops_reg, hops_next;
    logic [1:0]         north_reg, north_next;
    logic [1:0]         east_reg, east_next;
    logic [1:0]         south_reg, south_next;
    logic [1:0]         west_reg, west_next;
    logic               bad_reg, bad_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [COORD_W-1:0] dx_reg, dx_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    logic [SLOT_W-1:0]  base_reg, base_next;
    dir_t               dir_reg, dir_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [LAT_W:0]     hop_lat_reg, hop_lat_next;
    logic [LAT_W-1:0]   hop_busy_reg, hop_busy_next;
    logic [TIME_W-1:0]  m_reg, m_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;

    logic               of_we, lf_we;
    logic [SLOT_W-1:0]  waddr, raddr;
    logic [TIME_W-1:0]  of_wdata, lf_wdata;
    logic [TIME_W-1:0]  of_rdata, lf_rdata;

    logic               in_bad;
    dir_t               issue_dir;
    logic [LAT_W-1:0]   issue_lat;
    logic [LAT_W-1:0]   issue_floor;

    mxrt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_output_ram (
        .clk   (clk),
        .we    (of_we),
        .waddr (waddr),
        .wdata (of_wdata),
        .raddr (raddr),
        .rdata (of_rdata)
    );

    mxrt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (lf_we),
        .waddr (waddr),
        .wdata (lf_wdata),
        .raddr (raddr),
        .rdata (lf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_lat_reg <= LAT_W'(1);
            north_lat_reg  <= LAT_W'(1);
            east_lat_reg   <= LAT_W'(1);
            south_lat_reg  <= LAT_W'(1);
            west_lat_reg   <= LAT_W'(1);
            busy_lat_reg   <= LAT_W'(1);
            cycle_time_reg <= LAT_W'(1);
            async_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROUTER_LAT: router_lat_reg <= cfg_data;
                REG_NORTH_LAT:  north_lat_reg  <= cfg_data;
                REG_EAST_LAT:   east_lat_reg   <= cfg_data;
                REG_SOUTH_LAT:  south_lat_reg  <= cfg_data;
                REG_WEST_LAT:   west_lat_reg   <= cfg_data;
                REG_BUSY_LAT:   busy_lat_reg   <= cfg_data;
                REG_CYCLE_TIME: cycle_time_reg <= cfg_data;
                REG_ASYNC_MODE: async_mode_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        t_reg        <= t_next;
        cong_reg     <= cong_next;
        trav_reg     <= trav_next;
        busy_sum_reg <= busy_sum_next;
        hops_reg     <= hops_next;
        north_reg    <= north_next;
        east_reg     <= east_next;
        south_reg    <= south_next;
        west_reg     <= west_next;
        bad_reg      <= bad_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        base_reg     <= base_next;
        dir_reg      <= dir_next;
        slot_reg     <= slot_next;
        hop_lat_reg  <= hop_lat_next;
        hop_busy_reg <= hop_busy_next;
        m_reg        <= m_next;
        start_reg    <= start_next;
        wait_reg     <= wait_next;
    end

    assign in_bad = ({1'b0, in_item.src_router} >= ID_LIMIT)
                 || ({1'b0, in_item.dst_router} >= ID_LIMIT);

    always_comb
    begin
        priority if (cx_reg < dx_reg)
        begin
            issue_dir = DIR_EAST;
        end
        else if (cx_reg > dx_reg)
        begin
            issue_dir = DIR_WEST;
        end
        else if (cy_reg < dy_reg)
        begin
            issue_dir = DIR_NORTH;
        end
        else if (cy_reg > dy_reg)
        begin
            issue_dir = DIR_SOUTH;
        end
        else
        begin
            issue_dir = DIR_LOCAL;
        end
    end

    always_comb
    begin
        unique case (issue_dir)
            DIR_NORTH: issue_lat = north_lat_reg;
            DIR_EAST:  issue_lat = east_lat_reg;
            DIR_SOUTH: issue_lat = south_lat_reg;
            DIR_WEST:  issue_lat = west_lat_reg;
            default:   issue_lat = '0;
        endcase
    end

    assign issue_floor = async_mode_reg ? issue_lat : cycle_time_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        t_next         = t_reg;
        cong_next      = cong_reg;
        trav_next      = trav_reg;
        busy_sum_next  = busy_sum_reg;
        hops_next      = hops_reg;
        north_next     = north_reg;
        east_next      = east_reg;
        south_next     = south_reg;
        west_next      = west_reg;
        bad_next       = bad_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        base_next      = base_reg;
        dir_next       = dir_reg;
        slot_next      = slot_reg;
        hop_lat_next   = hop_lat_reg;
        hop_busy_next  = hop_busy_reg;
        m_next         = m_reg;
        start_next     = start_reg;
        wait_next      = wait_reg;
        in_ready       = 1'b0;
        of_we          = 1'b0;
        lf_we          = 1'b0;
        waddr          = slot_reg;
        raddr          = slot_reg;
        of_wdata       = start_reg + TIME_W'(hop_lat_reg);
        lf_wdata       = start_reg + TIME_W'(hop_busy_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                of_we    = 1'b1;
                lf_we    = 1'b1;
                waddr    = clr_cnt_reg;
                of_wdata = '0;
                lf_wdata = '0;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    t_next        = in_item.send_time;
                    cong_next     = '0;
                    trav_next     = '0;
                    busy_sum_next = '0;
                    hops_next     = '0;
                    north_next    = '0;
                    east_next     = '0;
                    south_next    = '0;
                    west_next     = '0;
                    bad_next      = in_bad;
                    cx_next       = x_tab[in_item.src_router];
                    cy_next       = y_tab[in_item.src_router];
                    dx_next       = x_tab[in_item.dst_router];
                    dy_next       = y_tab[in_item.dst_router];
                    base_next     = base_tab[in_item.src_router];
                    state_next    = in_bad ? S_DONE : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                dir_next      = issue_dir;
                slot_next     = base_reg + SLOT_W'(issue_dir);
                raddr         = slot_next;
                hop_lat_next  = (LAT_W + 1)'(router_lat_reg) + (LAT_W + 1)'(issue_lat);
                hop_busy_next = (busy_lat_reg > issue_floor) ? busy_lat_reg : issue_floor;
                unique case (issue_dir)
                    DIR_EAST:
                    begin
                        cx_next   = cx_reg + COORD_W'(1);
                        base_next = base_reg + STEP_X;
                    end
                    DIR_WEST:
                    begin
                        cx_next   = cx_reg - COORD_W'(1);
                        base_next = base_reg - STEP_X;
                    end
                    DIR_NORTH:
                    begin
                        cy_next   = cy_reg + COORD_W'(1);
                        base_next = base_reg + STEP_Y;
                    end
                    DIR_SOUTH:
                    begin
                        cy_next   = cy_reg - COORD_W'(1);
                        base_next = base_reg - STEP_Y;
                    end
                    default:
                    begin
                        base_next = base_reg;
                    end
                endcase
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (dir_reg == DIR_LOCAL || of_rdata > lf_rdata)
                begin
                    m_next = of_rdata;
                end
                else
                begin
                    m_next = lf_rdata;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (m_reg > t_reg)
                begin
                    start_next = m_reg;
                    wait_next  = m_reg - t_reg;
                end
                else
                begin
                    start_next = t_reg;
                    wait_next  = '0;
                end
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                of_we     = 1'b1;
                t_next    = of_wdata;
                cong_next = cong_reg + wait_reg;
                trav_next = trav_reg + TIME_W'(hop_lat_reg);
                if (dir_reg == DIR_LOCAL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lf_we         = 1'b1;
                    busy_sum_next = busy_sum_reg + TIME_W'(hop_busy_reg);
                    hops_next     = hops_reg + 3'd1;
                    state_next    = S_ISSUE;
                end
                unique case (dir_reg)
                    DIR_NORTH: north_next = north_reg + 2'd1;
                    DIR_EAST:  east_next  = east_reg + 2'd1;
                    DIR_SOUTH: south_next = south_reg + 2'd1;
                    DIR_WEST:  west_next  = west_reg + 2'd1;
                    default:   north_next = north_reg;
                endcase
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (bad_reg)
                    begin
                        out_item_next        = '0;
                        out_item_next.bad_id = 1'b1;
                    end
                    else
                    begin
                        out_item_next.arrival_time     = t_reg;
                        out_item_next.congestion_total = cong_reg;
                        out_item_next.traversal_total  = trav_reg;
                        out_item_next.busy_total       = busy_sum_reg;
                        out_item_next.hop_count        = hops_reg;
                        out_item_next.north_hops       = north_reg;
                        out_item_next.east_hops        = east_reg;
                        out_item_next.south_hops       = south_reg;
                        out_item_next.west_hops        = west_reg;
                        out_item_next.bad_id           = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_bad_skips_route: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_bad) |=> (state_reg == S_DONE))
        else $error("item with a bad router id did not go straight to the result");

    a_start_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (start_reg >= t_reg))
        else $error("hop start is earlier than the packet time");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (slot_reg <= SLOT_LAST))
        else $error("reservation slot beyond the table");

    a_local_ends_route: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && dir_reg == DIR_LOCAL) |=> (state_reg == S_DONE))
        else $error("local port reservation did not end the route");
`endif

endmodule
